### design/iks_pkg.sv
// Shared types and constants for the issue key token scanner.
// No dependencies; every design module imports this package.
package iks_pkg;

    // ASCII codes used by the byte classifier
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_DASH       = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

    // Depth of the queue between the classifier and the phase machine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Byte class as seen by the phase machine
    typedef enum logic [2:0] {
        CLS_SEP,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_UNDERSCORE,
        CLS_DASH
    } byte_cls_t;

    // One classified byte in flight through the queue
    typedef struct packed {
        byte_cls_t cls;
        logic      last;
    } iks_item_t;

endpackage

### design/iks_if.sv
// Handshake channel interfaces for the issue key token scanner.
// iks_in_if carries text bytes, iks_out_if carries scan results.
interface iks_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

interface iks_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_start;
    logic [15:0] match_end;
    logic        overflow;

    modport source (output valid, output found, output match_start, output match_end,
                    output overflow, input ready);
    modport sink (input valid, input found, input match_start, input match_end,
                  input overflow, output ready);
endinterface

### design/issue_key_token_scanner_top.sv
// Top level of the issue key token scanner: front end, queue and phase machine.
// Depends on iks_pkg, iks_if, iks_front, iks_queue and iks_back.
//
// Usage:
//   text   : valid/ready channel of text bytes; is_last marks the final byte.
//   result : valid/ready channel; one transfer per text, sent for its last byte,
//            giving found, match_start, match_end (exclusive) and overflow.
//   The first key token (letter, then letters/digits/underscores, a dash, then
//   one or more digits) of each text is reported; later keys are ignored.
//   Throughput: one byte per cycle, sustained, as long as results drain.
//   A last byte passes through the queue and then the result register before its result turns valid.
//   A four-entry queue sits between the classifier and the phase machine; when
//   the result receiver stalls, the held result stops the phase machine, and
//   the text channel keeps accepting bytes until the queue fills.
//   Positions saturate at MAX_TEXT_LEN; bytes beyond it set overflow.
//   Reset clears the scan state, the queue and any pending result; the block
//   accepts bytes in the first cycle after reset.
module issue_key_token_scanner_top
    import iks_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LEN = 65535
)
(
    input  logic      clk,
    input  logic      rst_n,
    iks_in_if.sink    text,
    iks_out_if.source result
);

    logic                   push;
    iks_item_t              push_item;
    logic                   pop;
    iks_item_t              head_item;
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;

    iks_front u_front (
        .text      (text),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    iks_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (full),
        .empty     (empty),
        .count     (count)
    );

    iks_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head_item (head_item),
        .pop       (pop),
        .result    (result)
    );

    // Queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // Backpressure on the text channel only comes from a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (count == QUEUE_CNT_W'(QUEUE_DEPTH)))
        else $error("text channel stalled with room in queue");

    // Draining a last byte always yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.last) |=> result.valid)
        else $error("last byte popped without a result");

    // A result without a key carries zero positions
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.found) |-> (result.match_start == 16'd0 &&
                                             result.match_end == 16'd0))
        else $error("no-key result with nonzero positions");

endmodule

### design/iks_front.sv
// Front end: accepts text bytes and classifies them for the phase machine.
// Depends on iks_pkg and iks_in_if; pushes into iks_queue.
module iks_front
    import iks_pkg::*;
(
    iks_in_if.sink    text,
    input  logic      full,
    output logic      push,
    output iks_item_t push_item
);

    byte_cls_t cls;

    // Classify the incoming byte
    always_comb
    begin
        cls = CLS_SEP;
        if ((text.text_byte >= CHAR_UPPER_A && text.text_byte <= CHAR_UPPER_Z) ||
            (text.text_byte >= CHAR_LOWER_A && text.text_byte <= CHAR_LOWER_Z))
        begin
            cls = CLS_LETTER;
        end
        else if (text.text_byte >= CHAR_DIGIT_0 && text.text_byte <= CHAR_DIGIT_9)
        begin
            cls = CLS_DIGIT;
        end
        else if (text.text_byte == CHAR_UNDERSCORE)
        begin
            cls = CLS_UNDERSCORE;
        end
        else if (text.text_byte == CHAR_DASH)
        begin
            cls = CLS_DASH;
        end
    end

    // Accept a transfer whenever the queue has room
    assign text.ready = !full;
    assign push       = text.valid && !full;
    assign push_item  = '{cls: cls, last: text.is_last};

endmodule

### design/iks_queue.sv
// Short FIFO of classified bytes between the front end and the phase machine.
// Depends on iks_pkg for the item type and depth.
module iks_queue
    import iks_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  iks_item_t              push_item,
    input  logic                   pop,
    output iks_item_t              head_item,
    output logic                   full,
    output logic                   empty,
    output logic [QUEUE_CNT_W-1:0] count
);

    iks_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] head_reg;
    logic [QUEUE_IDX_W-1:0] tail_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[head_reg];
    assign count     = count_reg;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + QUEUE_IDX_W'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + QUEUE_IDX_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_item;
        end
    end

endmodule

### design/iks_back.sv
// Back end: token phase machine, position tracking and result register.
// Depends on iks_pkg and iks_out_if; pops from iks_queue.
module iks_back
    import iks_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LEN = 65535
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  iks_item_t  head_item,
    output logic       pop,
    iks_out_if.source  result
);

    localparam int POS_W = $clog2(MAX_TEXT_LEN + 1);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 16;
    localparam logic [POS_W-1:0] MAX_POS = MAX_TEXT_LEN[POS_W-1:0];

    typedef enum logic [2:0] {
        PH_OUTSIDE,
        PH_PREFIX,
        PH_DASH,
        PH_NUMBER,
        PH_SPOILED
    } phase_t;

    phase_t             phase_reg,     phase_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [POS_W-1:0]   tok_start_reg, tok_start_next;
    logic               key_found_reg, key_found_next;
    logic [POS_W-1:0]   key_start_reg, key_start_next;
    logic [POS_W-1:0]   key_end_reg,   key_end_next;
    logic               ovf_reg,       ovf_next;

    logic               res_valid_reg;
    logic               res_found_reg;
    logic [15:0]        res_start_reg;
    logic [15:0]        res_end_reg;
    logic               res_ovf_reg;

    logic               in_range;
    logic               fin_found;
    logic [POS_W-1:0]   fin_start;
    logic [POS_W-1:0]   fin_end;
    logic [EXT_W-1:0]   fin_start_ext;
    logic [EXT_W-1:0]   fin_end_ext;

    // Pop whenever the result slot is free or being drained this cycle
    assign pop = !empty && (!res_valid_reg || result.ready);

    // Advance the token phase for one byte
    always_comb
    begin
        in_range       = (pos_reg < MAX_POS);
        phase_next     = phase_reg;
        tok_start_next = tok_start_reg;
        key_found_next = key_found_reg;
        key_start_next = key_start_reg;
        key_end_next   = key_end_reg;

        if (head_item.cls != CLS_SEP)
        begin
            if (!in_range)
            begin
                phase_next = PH_SPOILED;
            end
            else
            begin
                unique case (phase_reg)
                    PH_OUTSIDE:
                    begin
                        tok_start_next = pos_reg;
                        phase_next = (head_item.cls == CLS_LETTER) ? PH_PREFIX : PH_SPOILED;
                    end
                    PH_PREFIX:
                    begin
                        phase_next = (head_item.cls == CLS_DASH) ? PH_DASH : PH_PREFIX;
                    end
                    PH_DASH, PH_NUMBER:
                    begin
                        phase_next = (head_item.cls == CLS_DIGIT) ? PH_NUMBER : PH_SPOILED;
                    end
                    default:
                    begin
                        phase_next = PH_SPOILED;
                    end
                endcase
            end
        end
        else
        begin
            // A separator closes the token; record it if it is the first key
            if (phase_reg == PH_NUMBER && !key_found_reg)
            begin
                key_found_next = 1'b1;
                key_start_next = tok_start_reg;
                key_end_next   = pos_reg;
            end
            phase_next = PH_OUTSIDE;
        end

        pos_next = in_range ? (pos_reg + POS_W'(1)) : pos_reg;
        ovf_next = ovf_reg || !in_range;
    end

    // Close an open key at the end of the text
    always_comb
    begin
        fin_found = key_found_next;
        fin_start = key_start_next;
        fin_end   = key_end_next;
        if (phase_next == PH_NUMBER && !key_found_next)
        begin
            fin_found = 1'b1;
            fin_start = tok_start_next;
            fin_end   = pos_next;
        end
        if (!fin_found)
        begin
            fin_start = '0;
            fin_end   = '0;
        end
        fin_start_ext = EXT_W'(fin_start);
        fin_end_ext   = EXT_W'(fin_end);
    end

    // Hold scan state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OUTSIDE;
            pos_reg       <= '0;
            tok_start_reg <= '0;
            key_found_reg <= 1'b0;
            key_start_reg <= '0;
            key_end_reg   <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_found_reg <= 1'b0;
            res_start_reg <= '0;
            res_end_reg   <= '0;
            res_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (pop && head_item.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (head_item.last)
                begin
                    // Emit the result and rearm for the next text
                    res_found_reg <= fin_found;
                    res_start_reg <= fin_start_ext[15:0];
                    res_end_reg   <= fin_end_ext[15:0];
                    res_ovf_reg   <= ovf_next;
                    phase_reg     <= PH_OUTSIDE;
                    pos_reg       <= '0;
                    tok_start_reg <= '0;
                    key_found_reg <= 1'b0;
                    key_start_reg <= '0;
                    key_end_reg   <= '0;
                    ovf_reg       <= 1'b0;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    pos_reg       <= pos_next;
                    tok_start_reg <= tok_start_next;
                    key_found_reg <= key_found_next;
                    key_start_reg <= key_start_next;
                    key_end_reg   <= key_end_next;
                    ovf_reg       <= ovf_next;
                end
            end
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.found       = res_found_reg;
    assign result.match_start = res_start_reg;
    assign result.match_end   = res_end_reg;
    assign result.overflow    = res_ovf_reg;

endmodule
